// ===== hw/rtl/depth_hole_fill_3x3_unit_defines.svh =====
// ----------------------------------------------------------------------------
// depth_hole_fill_3x3_unit_defines
// Assertion macros shared by the hole-fill unit; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DEPTH_HOLE_FILL_3X3_UNIT_DEFINES_SVH
`define DEPTH_HOLE_FILL_3X3_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define DHF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dhf: same-cycle check failed");
// next-cycle implication
`define DHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dhf: next-cycle check failed");
`else
`define DHF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DHF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/dhf_pkg.sv =====
// ----------------------------------------------------------------------------
// dhf_pkg
// Widths, register codes, issue word and helpers for the hole-fill unit.
// ----------------------------------------------------------------------------
package dhf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_DIM    = 5;
	localparam int BORDER     = 2;

	localparam int PIX_W      = 8;
	localparam int THR_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WID_W      = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
	localparam int PEND_W     = WID_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = HGT_W;

	localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
	localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);
	localparam logic [THR_W-1:0] THR_RST    = THR_W'(5);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = CFG_IDX_W'(2);

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// work word handed from the sequencer to the window stage
	typedef struct packed {
		logic             valid;
		logic             drain;
		logic             emit;
		logic             interior;
		logic             last;
		logic             from_older;
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
	} issue_t;

	function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
		if (v < WID_W'(MIN_DIM)) return WID_W'(MIN_DIM);
		if (v > WID_W'(MAX_WIDTH)) return WID_W'(MAX_WIDTH);
		return v;
	endfunction

	function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
		if (v < HGT_W'(MIN_DIM)) return HGT_W'(MIN_DIM);
		if (v > HGT_W'(MAX_HEIGHT)) return HGT_W'(MAX_HEIGHT);
		return v;
	endfunction

endpackage

// ===== hw/rtl/dhf_if.sv =====
// ----------------------------------------------------------------------------
// dhf_if
// Valid/ready channels of the hole-fill unit: pixel input, result, config.
// ----------------------------------------------------------------------------
interface dhf_in_if;
	import dhf_pkg::*;
	logic             valid;
	logic             ready;
	logic             command;
	logic [PIX_W-1:0] pixel_in;
	modport source(output valid, command, pixel_in, input ready);
	modport sink(input valid, command, pixel_in, output ready);
endinterface

interface dhf_out_if;
	import dhf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;
	modport source(output valid, pixel_out, frame_last, input ready);
	modport sink(input valid, pixel_out, frame_last, output ready);
endinterface

interface dhf_cfg_if;
	import dhf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dhf_ram.sv =====
// ----------------------------------------------------------------------------
// dhf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dhf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/dhf_seq.sv =====
// ----------------------------------------------------------------------------
// dhf_seq
// Config registers, raster counters, drain count and line memory addressing.
// ----------------------------------------------------------------------------
module dhf_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           accept,
	input  logic                           command,
	input  logic [dhf_pkg::PIX_W-1:0]      pixel_in,
	input  logic                           cfg_we,
	input  logic [dhf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           rd_en,
	output logic [dhf_pkg::COL_W-1:0]      rd_addr_older,
	output logic [dhf_pkg::COL_W-1:0]      rd_addr_newer,
	output logic [dhf_pkg::THR_W-1:0]      thr,
	output dhf_pkg::issue_t                issue_s1
);
	import dhf_pkg::*;

	logic [WID_W-1:0]  w_q;
	logic [HGT_W-1:0]  h_q;
	logic [THR_W-1:0]  thr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PEND_W-1:0] pend_q;

	logic             pix_item;
	logic             drain_item;
	logic             emit;
	logic             interior;
	logic             col_last;
	logic             row_last;
	logic [ROW_W-1:0] oy;
	logic [WID_W-1:0] ox;
	issue_t           issue;

	assign pix_item   = accept && (command == CMD_PIXEL) && (pend_q == '0);
	assign drain_item = accept && (command == CMD_DRAIN) && (pend_q != '0)
		&& ({1'b0, pend_q} <= ({1'b0, w_q} + (WID_W + 1)'(1)));
	assign rd_en      = pix_item || drain_item;

	assign rd_addr_older = pix_item ? col_q : COL_W'(w_q - WID_W'(1));
	assign rd_addr_newer = pix_item ? col_q : COL_W'(w_q - pend_q);

	// output position trails the input by one row and one pixel
	assign emit = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
	assign oy   = (col_q != '0) ? row_q - ROW_W'(1) : row_q - ROW_W'(2);
	assign ox   = (col_q != '0) ? {1'b0, col_q} - WID_W'(1) : w_q - WID_W'(1);
	assign interior = (oy >= ROW_W'(BORDER))
		&& (({1'b0, oy} + HGT_W'(BORDER + 1)) <= h_q)
		&& (ox >= WID_W'(BORDER))
		&& ((ox + WID_W'(BORDER + 1)) <= w_q);

	assign col_last = ({1'b0, col_q} + WID_W'(1)) == w_q;
	assign row_last = ({1'b0, row_q} + HGT_W'(1)) == h_q;

	always_comb begin
		issue            = '0;
		issue.valid      = rd_en;
		issue.drain      = drain_item;
		issue.emit       = pix_item && emit;
		issue.interior   = interior;
		issue.last       = pend_q == PEND_W'(1);
		issue.from_older = {1'b0, pend_q} == ({1'b0, w_q} + (WID_W + 1)'(1));
		issue.pix        = pixel_in;
		issue.col        = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WIDTH_RST;
			h_q    <= HEIGHT_RST;
			thr_q  <= THR_RST;
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					w_q    <= clamp_width(cfg_data[WID_W-1:0]);
					col_q  <= '0;
					row_q  <= '0;
					pend_q <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					h_q    <= clamp_height(cfg_data[HGT_W-1:0]);
					col_q  <= '0;
					row_q  <= '0;
					pend_q <= '0;
				end
				REG_EDGE_THRESHOLD: begin
					thr_q <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (pix_item) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					pend_q <= w_q + WID_W'(1);
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end else if (drain_item) begin
			pend_q <= pend_q - PEND_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
		end else if (en) begin
			issue_s1 <= issue;
		end
	end

	assign thr = thr_q;

endmodule

// ===== hw/rtl/dhf_win.sv =====
// ----------------------------------------------------------------------------
// dhf_win
// 3x3 window columns, hole-fill / spike filter and the result register.
// ----------------------------------------------------------------------------
module dhf_win (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  dhf_pkg::issue_t           issue_s1,
	input  logic [dhf_pkg::PIX_W-1:0] above2,
	input  logic [dhf_pkg::PIX_W-1:0] above1,
	input  logic [dhf_pkg::THR_W-1:0] thr,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [dhf_pkg::PIX_W-1:0] pixel_out,
	output logic                      frame_last
);
	import dhf_pkg::*;

	// only the window taps the filter looks at are kept
	logic [PIX_W-1:0] col_top_q;
	logic [PIX_W-1:0] col_mid_q;
	logic [PIX_W-1:0] col_mid_prev_q;
	logic [PIX_W-1:0] col_bot_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic             last_q;

	logic             shift;
	logic             load;
	logic [PIX_W-1:0] cen;
	logic [PIX_W-1:0] up;
	logic [PIX_W-1:0] dn;
	logic [PIX_W-1:0] lf;
	logic [PIX_W-1:0] rt;
	logic [PIX_W:0]   lf_t;
	logic [PIX_W:0]   rt_t;
	logic [PIX_W:0]   up_t;
	logic [PIX_W:0]   dn_t;
	logic [PIX_W:0]   sum_h;
	logic [PIX_W:0]   sum_v;
	logic             spike_h;
	logic             spike_v;
	logic [PIX_W-1:0] filt;
	logic [PIX_W-1:0] result;

	assign shift = en && issue_s1.valid && !issue_s1.drain;
	assign load  = en && issue_s1.valid && (issue_s1.drain || issue_s1.emit);

	// window as it stands after this pixel shifts in
	assign cen = col_mid_q;
	assign up  = col_top_q;
	assign dn  = col_bot_q;
	assign lf  = col_mid_prev_q;
	assign rt  = above1;

	assign lf_t  = {1'b0, lf} + {1'b0, thr};
	assign rt_t  = {1'b0, rt} + {1'b0, thr};
	assign up_t  = {1'b0, up} + {1'b0, thr};
	assign dn_t  = {1'b0, dn} + {1'b0, thr};
	assign sum_h = {1'b0, lf} + {1'b0, rt};
	assign sum_v = {1'b0, dn} + {1'b0, up};

	assign spike_h = ({1'b0, cen} > lf_t) && ({1'b0, cen} > rt_t) && (lf != '0) && (rt != '0);
	assign spike_v = ({1'b0, cen} > dn_t) && ({1'b0, cen} > up_t) && (dn != '0) && (up != '0);

	always_comb begin
		priority if (cen == '0) begin
			filt = (up != '0) ? up : lf;
		end else if (spike_h) begin
			filt = sum_h[PIX_W:1];
		end else if (spike_v) begin
			filt = sum_v[PIX_W:1];
		end else begin
			filt = cen;
		end
	end

	always_comb begin
		if (issue_s1.drain) begin
			result = issue_s1.from_older ? above2 : above1;
		end else begin
			result = issue_s1.interior ? filt : cen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_top_q      <= '0;
			col_mid_q      <= '0;
			col_mid_prev_q <= '0;
			col_bot_q      <= '0;
		end else if (shift) begin
			col_top_q      <= above2;
			col_mid_prev_q <= col_mid_q;
			col_mid_q      <= above1;
			col_bot_q      <= issue_s1.pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q <= result;
			last_q  <= issue_s1.drain && issue_s1.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_q;
	assign frame_last = last_q;

endmodule

// ===== hw/rtl/depth_hole_fill_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// depth_hole_fill_3x3_unit
// One pass of a 3x3 hole-fill and spike filter over a raster depth stream.
// ----------------------------------------------------------------------------
// The unit takes one word per clock on pixels (command pixel or drain) and
// returns filtered pixels on results in raster order, one row plus one pixel
// behind the input; after the last pixel of a frame, width + 1 drain words
// push out the rest, the final one flagged by frame_last. Sustained rate is
// one word per cycle while results are taken: each pixel does a single
// read-modify-write of each of the two 1024 x 8 line memories, read in the
// accept cycle and written back from the window stage, and a result is
// loaded into the output register when its word leaves the window stage.
// Input ready drops only while a result waits in the output register and
// the word in the window stage would produce another.
// The line memories get no clearing pass after reset: entries never written
// feed only border pixels, which pass through unfiltered. Geometry writes
// restart the frame; config is always ready and is meant to be written
// while the unit is idle.
// ----------------------------------------------------------------------------
`include "depth_hole_fill_3x3_unit_defines.svh"

module depth_hole_fill_3x3_unit (
	input logic      clk,
	input logic      arst_n,
	dhf_in_if.sink   pixels,
	dhf_out_if.source results,
	dhf_cfg_if.sink  cfg
);
	import dhf_pkg::*;

	// pipeline control
	logic   en;
	logic   accept;
	logic   s1_produces;
	logic   res_valid;
	issue_t issue_s1;

	// line memory ports
	logic             rd_en;
	logic [COL_W-1:0] rd_addr_older;
	logic [COL_W-1:0] rd_addr_newer;
	logic [PIX_W-1:0] rdata_older;
	logic [PIX_W-1:0] rdata_newer;
	logic             wr_en;
	logic [PIX_W-1:0] above2;
	logic [PIX_W-1:0] above1;
	logic [THR_W-1:0] thr;

	// bypass for a read that hits the entry written in the same cycle
	logic             fwd_older_q;
	logic             fwd_newer_q;
	logic [PIX_W-1:0] fwd_older_data_q;
	logic [PIX_W-1:0] fwd_newer_data_q;

	// stall only when the window stage has a word for a full output register
	assign s1_produces = issue_s1.valid && (issue_s1.drain || issue_s1.emit);
	assign en          = !(s1_produces && res_valid && !results.ready);
	assign pixels.ready = en;
	assign accept      = pixels.valid && en;

	assign cfg.ready = 1'b1;

	dhf_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.accept        (accept),
		.command       (pixels.command),
		.pixel_in      (pixels.pixel_in),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.rd_en         (rd_en),
		.rd_addr_older (rd_addr_older),
		.rd_addr_newer (rd_addr_newer),
		.thr           (thr),
		.issue_s1      (issue_s1)
	);

	// pixel words rotate the column: older <= newer, newer <= incoming pixel
	assign wr_en = en && issue_s1.valid && !issue_s1.drain;

	dhf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_older (
		.clk   (clk),
		.we    (wr_en),
		.waddr (issue_s1.col),
		.wdata (above1),
		.re    (rd_en),
		.raddr (rd_addr_older),
		.rdata (rdata_older)
	);

	dhf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_newer (
		.clk   (clk),
		.we    (wr_en),
		.waddr (issue_s1.col),
		.wdata (issue_s1.pix),
		.re    (rd_en),
		.raddr (rd_addr_newer),
		.rdata (rdata_newer)
	);

	// first drain word reads the older entry the last pixel is writing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_older_q <= 1'b0;
			fwd_newer_q <= 1'b0;
		end else if (rd_en) begin
			fwd_older_q <= wr_en && (issue_s1.col == rd_addr_older);
			fwd_newer_q <= wr_en && (issue_s1.col == rd_addr_newer);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_older_data_q <= above1;
			fwd_newer_data_q <= issue_s1.pix;
		end
	end

	assign above2 = fwd_older_q ? fwd_older_data_q : rdata_older;
	assign above1 = fwd_newer_q ? fwd_newer_data_q : rdata_newer;

	dhf_win u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.issue_s1   (issue_s1),
		.above2     (above2),
		.above1     (above1),
		.thr        (thr),
		.out_ready  (results.ready),
		.out_valid  (res_valid),
		.pixel_out  (results.pixel_out),
		.frame_last (results.frame_last)
	);

	assign results.valid = res_valid;

	// a pixel read never lands on the entry being written back (width >= 5)
	`DHF_ASSERT_IMPLY(a_pixel_read_no_overlap, clk, arst_n, wr_en && rd_en && (pixels.command == CMD_PIXEL), (rd_addr_older != issue_s1.col) && (rd_addr_newer != issue_s1.col))
	// a held result with another on the way must stop the input
	`DHF_ASSERT_IMPLY(a_stall_blocks_input, clk, arst_n, s1_produces && res_valid && !results.ready, !pixels.ready)
	// a result word moved out of the window stage shows up next cycle
	`DHF_ASSERT_NEXT(a_result_follows_issue, clk, arst_n, en && s1_produces, results.valid)

endmodule

// ===== sim/depth_hole_fill_3x3_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_hole_fill_3x3_unit_test
// Self-checking bench for the 3x3 depth hole-fill unit.
// ----------------------------------------------------------------------------
// Pixel and drain words go in on the pixel channel. An in-bench copy of the
// filter keeps its own line stores, window and frame counters, and predicts
// every filtered pixel with its frame_last flag. Each result word is checked
// against the oldest prediction.
// Stimulus starts with a hand-built 9x5 frame that hits each fill and spike
// rule. Random frames follow, with random geometry and threshold, broken
// frames, stray words and bursts of idling on both channels. One long
// result stall backs the unit up, one sender pause lets the pipe empty, and
// there is a 1024-wide frame and a 4096-high frame, both cut short.
// ----------------------------------------------------------------------------
module depth_hole_fill_3x3_unit_test;
	import dhf_pkg::*;

	// index past the register list, the unit must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;  // long result stall
	localparam int QUIET_LIMIT   = 4000; // cycles without any handshake
	localparam int WORD_TARGET   = 1650;
	localparam int CALM_WORDS    = 300;  // tail of the run without idling

	typedef enum {STYLE_DIRECTED, STYLE_UNIFORM, STYLE_DEPTH} pixel_style_t;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} filtered_t;

	// ------------------------------------------------------------------------
	// filter copy and result checker
	// ------------------------------------------------------------------------
	class hole_fill_scoreboard;
		logic [WID_W-1:0] width_reg;
		logic [HGT_W-1:0] height_reg;
		logic [THR_W-1:0] thr_reg;
		logic [PIX_W-1:0] older_row[MAX_WIDTH];
		logic [PIX_W-1:0] newer_row[MAX_WIDTH];
		logic [PIX_W-1:0] win[9];
		int unsigned      col;
		int unsigned      row;
		int unsigned      pend;
		filtered_t        filtered_q[$];
		int               errors;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			thr_reg    = THR_RST;
			foreach (older_row[i]) older_row[i] = '0;
			foreach (newer_row[i]) newer_row[i] = '0;
			foreach (win[i]) win[i] = '0;
			col    = 0;
			row    = 0;
			pend   = 0;
			errors = 0;
		endfunction

		function int unsigned geom(int unsigned v, int unsigned hi);
			if (v < MIN_DIM) return MIN_DIM;
			if (v > hi) return hi;
			return v;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH: width_reg = data[WID_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = data[HGT_W-1:0];
				REG_EDGE_THRESHOLD: begin
					thr_reg = data[THR_W-1:0];
					return;
				end
				default: return;
			endcase
			// geometry change drops the frame in progress
			col  = 0;
			row  = 0;
			pend = 0;
		endfunction

		// centre of the window after hole fill and spike smoothing
		function logic [PIX_W-1:0] fill_centre(bit interior);
			int unsigned c, up, dn, lf, rt, t;
			c  = win[4];
			up = win[1];
			dn = win[7];
			lf = win[3];
			rt = win[5];
			t  = thr_reg;
			if (!interior) return PIX_W'(c);
			if (c == 0) return PIX_W'((up != 0) ? up : lf);
			if (c > lf + t && c > rt + t && lf != 0 && rt != 0) return PIX_W'((lf + rt) >> 1);
			if (c > dn + t && c > up + t && dn != 0 && up != 0) return PIX_W'((dn + up) >> 1);
			return PIX_W'(c);
		endfunction

		function void note_word(logic cmd, logic [PIX_W-1:0] pix);
			int unsigned      w, h, r, c, k, oy, ox;
			logic [PIX_W-1:0] a, b;
			bit               interior;
			filtered_t        res;
			w = geom(width_reg, MAX_WIDTH);
			h = geom(height_reg, MAX_HEIGHT);
			if (cmd == CMD_DRAIN) begin
				if (pend == 0 || pend > w + 1) return;
				k = w + 1 - pend;
				res.pixel = (k == 0) ? older_row[w - 1] : newer_row[k - 1];
				pend--;
				res.last = (pend == 0);
				filtered_q = {filtered_q, res};
				return;
			end
			// pixels past the frame end are dropped while draining
			if (pend != 0) return;
			r = (row >= h) ? h - 1 : row;
			c = (col >= w) ? w - 1 : col;
			a = older_row[c];
			b = newer_row[c];
			older_row[c] = b;
			newer_row[c] = pix;
			for (k = 0; k < 3; k++) begin
				win[3 * k]     = win[3 * k + 1];
				win[3 * k + 1] = win[3 * k + 2];
			end
			win[2] = a;
			win[5] = b;
			win[8] = pix;
			if (r >= 2 || (r == 1 && c >= 1)) begin
				if (c >= 1) begin
					oy = r - 1;
					ox = c - 1;
				end else begin
					oy = r - 2;
					ox = w - 1;
				end
				interior  = oy >= 2 && oy + 3 <= h && ox >= 2 && ox + 3 <= w;
				res.pixel = fill_centre(interior);
				res.last  = 1'b0;
				filtered_q = {filtered_q, res};
			end
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h) begin
				r    = 0;
				c    = 0;
				pend = w + 1;
			end
			col = c;
			row = r;
		endfunction

		function void check_pixel(logic [PIX_W-1:0] pix, logic last);
			filtered_t want;
			if (filtered_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual pixel_out=%0d frame_last=%0b",
					$time, pix, last);
				return;
			end
			want = filtered_q.pop_front();
			if (pix !== want.pixel) begin
				errors++;
				$display("%0t: pixel_out mismatch: expected %0d, actual %0d",
					$time, want.pixel, pix);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: frame_last mismatch: expected %0b, actual %0b",
					$time, want.last, last);
			end
		endfunction

		function int outstanding();
			return filtered_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, channels and the unit
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;

	dhf_in_if  pix_ch();
	dhf_out_if res_ch();
	dhf_cfg_if cfg_ch();

	depth_hole_fill_3x3_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_ch),
		.results(res_ch),
		.cfg(cfg_ch)
	);

	hole_fill_scoreboard sb = new();

	int idle_odds = 3;   // 0 turns idling off, otherwise 1 in idle_odds+1 chance
	bit hold_req  = 1'b0;
	int hold_at   = -1;  // frame word that starts the long result stall
	int pause_at  = -1;  // frame word before which the sender waits for all results
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// result side: random stalls, plus the long hold counted here
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// check results before noting the input word taken at the same edge
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_pixel(res_ch.pixel_out, res_ch.frame_last);
		if (arst_n && pix_ch.valid && pix_ch.ready)
			sb.note_word(pix_ch.command, pix_ch.pixel_in);
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// one word on the pixel channel, with an optional idle burst first
	task automatic send_word(logic cmd, logic [PIX_W-1:0] pix);
		if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_ch.valid    <= 1'b1;
		pix_ch.command  <= cmd;
		pix_ch.pixel_in <= pix;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// register write; valid stays up so back-to-back writes need no gap
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.note_config(idx, data);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] raw_w, logic [CFG_DATA_W-1:0] raw_h,
			logic [CFG_DATA_W-1:0] raw_t);
		write_reg(REG_EDGE_THRESHOLD, raw_t);
		write_reg(REG_IMAGE_WIDTH, raw_w);
		write_reg(REG_IMAGE_HEIGHT, raw_h);
		cfg_ch.valid <= 1'b0;
	endtask

	// stop sending and wait until every predicted word is back
	task automatic wait_results();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// idle point: a row-0 pixel may still be in the pipe with no result
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(pixel_style_t style, int r, int c);
		case (style)
			STYLE_DIRECTED: begin
				// 9x5 frame, interior is row 2, columns 2..6, background 50
				case (r * 10 + c)
					0: return 8'd255;    // full-scale corner passes
					8: return 8'd0;      // empty edge pixel stays empty
					48: return 8'd255;   // last pixel of the frame
					12: return 8'd0;
					21: return 8'd70;
					22: return 8'd0;     // hole, nothing above: takes left 70
					13: return 8'd90;
					23: return 8'd0;     // hole: takes 90 from above
					14: return 8'd0;
					24: return 8'd0;     // hole with above and left empty stays empty
					15: return 8'd30;
					25: return 8'd240;   // left empty: vertical mean of 30 and 20
					35: return 8'd20;
					26: return 8'd250;   // horizontal spike: mean of 240 and 20
					27: return 8'd20;
					default: return 8'd50;
				endcase
			end
			STYLE_UNIFORM: return PIX_W'($urandom);
			default: begin
				// sparse depth: holes, spikes, smooth surface
				case ($urandom_range(0, 9))
					0, 1, 2: return '0;
					3: return PIX_W'($urandom_range(180, 255));
					default: return PIX_W'($urandom_range(30, 60));
				endcase
			end
		endcase
	endfunction

	// one frame of pixels then its drain words; cut < w*h abandons the frame.
	// stray drains and pixels are mixed in and not counted
	task automatic send_frame(int w, int h, int cut, pixel_style_t style, output int sent);
		sent = 0;
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				if (sent == cut) return;
				if (sent == hold_at) begin
					hold_req = 1'b1;
					hold_at  = -1;
				end
				if (sent == pause_at) begin
					pause_at = -1;
					wait_results();
				end
				if ($urandom_range(0, 30) == 0) send_word(CMD_DRAIN, PIX_W'($urandom));
				send_word(CMD_PIXEL, pick_pixel(style, r, c));
				sent++;
			end
		end
		for (int d = 0; d <= w; d++) begin
			send_word(CMD_DRAIN, PIX_W'($urandom));
			sent++;
			// a pixel past the frame end while draining must be dropped
			if (d < w && (d == 0 || $urandom_range(0, 15) == 0))
				send_word(CMD_PIXEL, PIX_W'($urandom));
		end
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		int                    w, h, thr, cut, nframes, sent, phase, stim_words;
		logic [CFG_DATA_W-1:0] raw_w, raw_h, raw_t;
		pixel_style_t          style;

		arst_n          <= 1'b0;
		pix_ch.valid    <= 1'b0;
		pix_ch.command  <= CMD_PIXEL;
		pix_ch.pixel_in <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= REG_IMAGE_WIDTH;
		cfg_ch.data     <= '0;
		stim_words = 0;
		phase      = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: drain with nothing pending, then the hand-built frame
		send_word(CMD_DRAIN, '1);
		settle();
		configure(CFG_DATA_W'(9), CFG_DATA_W'(5), CFG_DATA_W'(5));
		send_frame(9, 5, 45, STYLE_DIRECTED, sent);
		settle();

		// random phases; a few fixed ones hit the extremes and the pressure cases
		while (stim_words < WORD_TARGET || phase < 8) begin
			phase++;
			w       = $urandom_range(5, 20);
			h       = $urandom_range(5, 9);
			nframes = $urandom_range(1, 3);
			// fixed phases send one frame each to keep the run near its target
			if (phase <= 8) nframes = 1;
			case ($urandom_range(0, 5))
				0: thr = 0;
				1: thr = 255;
				2, 3: thr = $urandom_range(1, 12);
				default: thr = $urandom_range(0, 255);
			endcase
			if (stim_words + CALM_WORDS >= WORD_TARGET) begin
				idle_odds = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_odds = 0;
					1: idle_odds = 2;
					2: idle_odds = 5;
					default: idle_odds = 10;
				endcase
			end
			// upper data bits beyond each register's width must be dropped
			raw_w = CFG_DATA_W'($urandom);
			raw_w[WID_W-1:0] = WID_W'(w);
			raw_h = CFG_DATA_W'(h);
			raw_t = CFG_DATA_W'($urandom);
			case (phase)
				1: begin
					// below the minimum on both axes, used as 5x5
					raw_w = CFG_DATA_W'(0);
					raw_h = CFG_DATA_W'(4);
					w     = 5;
					h     = 5;
				end
				2: hold_at = 2 * w + 3;
				3: pause_at = (w * h) / 2;
				4: thr = 255;
				5: thr = 0;
				6: write_reg(REG_SPARE, '1);
				7: begin
					// widest frame, from an over-range width with all bits set
					raw_w   = CFG_DATA_W'(2047);
					raw_h   = CFG_DATA_W'(5);
					w       = MAX_WIDTH;
					h       = 5;
					nframes = 1;
				end
				8: begin
					// tallest frame, abandoned after 30 rows
					raw_w   = CFG_DATA_W'(5);
					raw_h   = CFG_DATA_W'(8191);
					w       = 5;
					h       = MAX_HEIGHT;
					nframes = 1;
				end
				default: ;
			endcase
			raw_t[THR_W-1:0] = THR_W'(thr);
			configure(raw_w, raw_h, raw_t);

			for (int f = 0; f < nframes; f++) begin
				cut = w * h;
				if (phase == 8)
					cut = 150;
				else if (phase == 7)
					cut = MAX_WIDTH + 8;   // past the row wrap, a few results from row one
				else if (f == nframes - 1 && phase != 2 && phase != 3 &&
						$urandom_range(0, 4) == 0)
					cut = $urandom_range(1, w * h - 1);
				style = ($urandom_range(0, 2) == 0) ? STYLE_UNIFORM : STYLE_DEPTH;
				send_frame(w, h, cut, style, sent);
				stim_words += sent;
			end
			settle();
		end

		// all stimulus in: let the pipe empty, then give the verdict
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dhf_pkg.sv
hw/rtl/dhf_if.sv
hw/rtl/dhf_ram.sv
hw/rtl/dhf_seq.sv
hw/rtl/dhf_win.sv
hw/rtl/depth_hole_fill_3x3_unit.sv
sim/depth_hole_fill_3x3_unit_test.sv
